// ===== rtl/utsp_pkg.sv =====
package utsp_pkg;

  localparam int MAX_DIM = 4;
  localparam int IDX_W   = 2;
  localparam int NENT    = MAX_DIM * MAX_DIM;

  // Q8.24 jitter steps for the first and the second factoring attempt
  localparam logic [63:0] JIT1 = 64'd17;
  localparam logic [63:0] JIT2 = 64'd16794;
  localparam logic signed [63:0] S_CLAMP = 64'sd274877906944;

  localparam logic [1:0] REG_DIMS    = 2'd0;
  localparam logic [1:0] REG_SAMPLES = 2'd1;

  localparam logic OP_MEAN   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic             mean_wr;
    logic             cov_clr;
    logic             dev_wr;
    logic             mul_dev;
    logic             acc_cov;
    logic             pdiv_start;
    logic             p_wr;
    logic             s_load;
    logic             la_rd;
    logic             lb_mul;
    logic             s_sub;
    logic             s_clamp;
    logic             sqrt_start;
    logic             ldiv_start;
    logic             l_wr_sqrt;
    logic             l_wr_div;
    logic             emit;
    logic             out_load;
    logic             out_fail;
    logic             retry;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] r;
    logic [3:0]       pt;
    logic [IDX_W-1:0] el;
    logic             last;
    logic [2:0]       k;
    logic [15:0]      m1;
  } utsp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic s_le0;
  } utsp_stat_t;

  // saturate a sign and magnitude pair to signed 32 bits
  function automatic logic [31:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [31:0] res;
    if (!neg) begin
      res = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      res = (mag > 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end
    return res;
  endfunction

  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] res;
    if (v[32] != v[31]) begin
      res = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic [63:0] jitter(input logic [2:0] k, input logic retry);
    logic [63:0] base;
    base = retry ? JIT2 : JIT1;
    return base * {61'd0, k};
  endfunction

endpackage

// ===== rtl/utsp_divider.sv =====
module utsp_divider import utsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] dvs_q, dvs_d;
  logic [64:0] rem_sh;
  logic [64:0] rem_sub;

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    rem_sh  = {rem_q, quo_q[63]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!rem_sub[64]) begin
        rem_d = rem_sub[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh[63:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/utsp_sqrt.sv =====
module utsp_sqrt import utsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] v_q, v_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic [63:0] trial;

  // digit-by-digit square root, two radicand bits per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    trial  = res_q + bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = radicand_i;
      res_d  = '0;
      bit_d  = 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

// ===== rtl/utsp_datapath.sv =====
module utsp_datapath import utsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  utsp_cmd_t   cmd_i,
  input  logic [31:0] in_value_i,
  output utsp_stat_t  stat_o,
  output logic [31:0] value_res_o,
  output logic [3:0]  point_index_o,
  output logic [1:0]  element_index_o,
  output logic        failed_o,
  output logic        last_o
);

  logic [31:0] mean_q [MAX_DIM];
  logic [31:0] dev_q  [MAX_DIM];
  logic [31:0] fac_q  [NENT];
  logic [63:0] cov_q  [NENT];

  logic signed [31:0] dev_e_q;
  logic signed [31:0] la_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] s_q;
  logic               neg_q;

  logic [31:0] val_q;
  logic [3:0]  pt_q;
  logic [1:0]  el_q;
  logic        fail_q;
  logic        last_q;

  logic [IDX_W-1:0]   mean_addr;
  logic [2*IDX_W-1:0] ent;
  logic [2*IDX_W-1:0] fac_addr;
  logic [31:0]        mean_rd;
  logic [31:0]        dev_rd;
  logic [31:0]        fac_rd;
  logic signed [63:0] cov_ent;
  logic [32:0]        diff;
  logic [31:0]        dev_new;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod_full;
  logic [64:0]        acc_sum;
  logic [63:0]        acc_sat;
  logic signed [63:0] kp;
  logic signed [63:0] adj;
  logic [63:0]        s_mag;
  logic [63:0]        cov_mag;
  logic               div_start;
  logic [63:0]        div_dvd;
  logic [63:0]        div_dvs;
  logic               div_done;
  logic [63:0]        quot;
  logic               sqrt_done;
  logic [31:0]        root;
  logic [31:0]        q_sat;
  logic [31:0]        p_val;
  logic [31:0]        lsel;
  logic [31:0]        emit_val;

  assign mean_addr = cmd_i.emit ? cmd_i.el : cmd_i.i;
  assign ent       = {cmd_i.i, cmd_i.j};
  assign mean_rd   = mean_q[mean_addr];
  assign dev_rd    = dev_q[cmd_i.j];
  assign cov_ent   = cov_q[ent];

  always_comb begin
    if (cmd_i.la_rd) begin
      fac_addr = {cmd_i.i, cmd_i.r};
    end else if (cmd_i.lb_mul) begin
      fac_addr = {cmd_i.j, cmd_i.r};
    end else if (cmd_i.ldiv_start) begin
      fac_addr = {cmd_i.j, cmd_i.j};
    end else begin
      fac_addr = {cmd_i.el, cmd_i.r};
    end
  end
  assign fac_rd = fac_q[fac_addr];

  assign diff    = {in_value_i[31], in_value_i} - {mean_rd[31], mean_rd};
  assign dev_new = sat33(diff);

  // one shared multiplier: deviation products, then factor products
  assign mul_a     = cmd_i.mul_dev ? dev_e_q : la_q;
  assign mul_b     = cmd_i.mul_dev ? $signed(dev_rd) : $signed(fac_rd);
  assign prod_full = mul_a * mul_b;

  assign acc_sum = {cov_ent[63], cov_ent} + {prod_q[63], prod_q};
  always_comb begin
    if (acc_sum[64] != acc_sum[63]) begin
      acc_sat = acc_sum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      acc_sat = acc_sum[63:0];
    end
  end

  assign kp      = cov_ent * $signed({61'd0, cmd_i.k});
  assign adj     = prod_q + (prod_q[63] ? 64'sd16777215 : 64'sd0);
  assign s_mag   = s_q[63] ? 64'(-s_q) : 64'(s_q);
  assign cov_mag = cov_ent[63] ? 64'(-cov_ent) : 64'(cov_ent);

  assign div_start = cmd_i.pdiv_start | cmd_i.ldiv_start;
  assign div_dvd   = cmd_i.pdiv_start ? cov_mag : {s_mag[39:0], 24'd0};
  assign div_dvs   = cmd_i.pdiv_start ? {24'd0, cmd_i.m1, 24'd0} : {32'd0, fac_rd};

  utsp_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  utsp_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i ({s_q[39:0], 24'd0}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  assign q_sat = sat_mag(neg_q, quot);
  assign p_val = (cmd_i.m1 == '0) ? 32'd0 : q_sat;

  // upper triangle of the factor reads as zero
  assign lsel = (cmd_i.el >= cmd_i.r) ? fac_rd : 32'd0;
  always_comb begin
    if (cmd_i.pt == '0) begin
      emit_val = mean_rd;
    end else if (cmd_i.pt <= {1'b0, cmd_i.k}) begin
      emit_val = sat33({mean_rd[31], mean_rd} + {lsel[31], lsel});
    end else begin
      emit_val = sat33({mean_rd[31], mean_rd} - {lsel[31], lsel});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NENT; n++) cov_q[n] <= '0;
    end else if (cmd_i.cov_clr) begin
      for (int n = 0; n < NENT; n++) cov_q[n] <= '0;
    end else if (cmd_i.acc_cov) begin
      cov_q[ent] <= acc_sat;
    end else if (cmd_i.p_wr) begin
      cov_q[ent] <= {{32{p_val[31]}}, p_val};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_wr) mean_q[cmd_i.i] <= in_value_i;
    if (cmd_i.dev_wr) begin
      dev_q[cmd_i.i] <= dev_new;
      dev_e_q        <= dev_new;
    end
    if (cmd_i.mul_dev || cmd_i.lb_mul) prod_q <= prod_full;
    if (cmd_i.la_rd) la_q <= fac_rd;
    if (cmd_i.s_load) begin
      s_q <= kp + ((cmd_i.i == cmd_i.j) ? $signed(jitter(cmd_i.k, cmd_i.retry)) : 64'sd0);
    end else if (cmd_i.s_sub) begin
      s_q <= s_q - (adj >>> 24);
    end else if (cmd_i.s_clamp) begin
      if (s_q > S_CLAMP) begin
        s_q <= S_CLAMP;
      end else if (s_q < -S_CLAMP) begin
        s_q <= -S_CLAMP;
      end
    end
    if (cmd_i.pdiv_start) neg_q <= cov_ent[63];
    if (cmd_i.ldiv_start) neg_q <= s_q[63];
    if (cmd_i.l_wr_sqrt) fac_q[ent] <= sat_mag(1'b0, {32'd0, root});
    if (cmd_i.l_wr_div) fac_q[ent] <= q_sat;
    if (cmd_i.out_load) begin
      val_q  <= cmd_i.out_fail ? 32'd0 : emit_val;
      pt_q   <= cmd_i.out_fail ? 4'd0 : cmd_i.pt;
      el_q   <= cmd_i.out_fail ? 2'd0 : cmd_i.el;
      fail_q <= cmd_i.out_fail;
      last_q <= cmd_i.out_fail | cmd_i.last;
    end
  end

  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.s_le0     = s_q[63] | (s_q == '0);

  assign value_res_o     = val_q;
  assign point_index_o   = pt_q;
  assign element_index_o = el_q;
  assign failed_o        = fail_q;
  assign last_o          = last_q;

endmodule

// ===== rtl/utsp_ctrl.sv =====
module utsp_ctrl import utsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  utsp_stat_t  stat_i,
  output utsp_cmd_t   cmd_o
);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'h0001,
    ST_MUL    = 15'h0002,
    ST_ACC    = 15'h0004,
    ST_PDIV   = 15'h0008,
    ST_PWAIT  = 15'h0010,
    ST_SLOAD  = 15'h0020,
    ST_RDA    = 15'h0040,
    ST_RDB    = 15'h0080,
    ST_SUB    = 15'h0100,
    ST_CLAMP  = 15'h0200,
    ST_CHECK  = 15'h0400,
    ST_SQWAIT = 15'h0800,
    ST_LDWAIT = 15'h1000,
    ST_EMIT   = 15'h2000,
    ST_FAIL   = 15'h4000
  } state_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_MEAN   = 3'b010,
    PH_SAMPLE = 3'b100
  } phase_e;

  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [2:0]       dims_q, dims_d;
  logic [15:0]      samples_q, samples_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, r_q, r_d, el_q, el_d;
  logic [15:0]      si_q, si_d;
  logic [3:0]       pt_q, pt_d;
  logic             retry_q, retry_d;
  logic             out_valid_q, out_valid_d;

  logic [2:0]       k;
  logic [15:0]      m1;
  logic [IDX_W-1:0] ec;
  logic             i_last, el_last, j_eq_i, pair_done, slot_free, pt_final;
  logic [IDX_W-1:0] adv_i, adv_j;
  logic [3:0]       col_full;

  assign k  = (dims_q == 3'd0) ? 3'd1 : ((dims_q > 3'd4) ? 3'd4 : dims_q);
  assign m1 = (samples_q == 16'd0) ? 16'd0 : samples_q - 16'd1;

  assign i_last    = ({1'b0, i_q} + 3'd1) == k;
  assign el_last   = ({1'b0, el_q} + 3'd1) == k;
  assign j_eq_i    = j_q == i_q;
  assign pair_done = j_eq_i && i_last;
  assign adv_i     = j_eq_i ? i_q + 2'd1 : i_q;
  assign adv_j     = j_eq_i ? 2'd0 : j_q + 2'd1;
  assign slot_free = !out_valid_q || out_ready_i;
  assign pt_final  = pt_q == {k, 1'b0};
  assign col_full  = (pt_q <= {1'b0, k}) ? pt_q - 4'd1 : pt_q - 4'd1 - {1'b0, k};

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    dims_d    = dims_q;
    samples_d = samples_q;
    i_d       = i_q;
    j_d       = j_q;
    r_d       = r_q;
    si_d      = si_q;
    pt_d      = pt_q;
    el_d      = el_q;
    retry_d   = retry_q;
    ec        = i_q;
    in_ready_o = 1'b0;

    cmd_o       = '0;
    cmd_o.i     = i_q;
    cmd_o.j     = j_q;
    cmd_o.r     = r_q;
    cmd_o.pt    = pt_q;
    cmd_o.el    = el_q;
    cmd_o.k     = k;
    cmd_o.m1    = m1;
    cmd_o.retry = retry_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (opcode_i == OP_MEAN) begin
            // a mean element outside the mean phase opens a new step
            if (phase_q != PH_MEAN) begin
              cmd_o.cov_clr = 1'b1;
              ec            = '0;
              si_d          = '0;
              phase_d       = PH_MEAN;
            end
            cmd_o.i       = ec;
            cmd_o.mean_wr = 1'b1;
            if (({1'b0, ec} + 3'd1) >= k) begin
              i_d     = '0;
              phase_d = PH_SAMPLE;
            end else begin
              i_d = ec + 2'd1;
            end
          end else if (phase_q == PH_SAMPLE) begin
            cmd_o.dev_wr = 1'b1;
            j_d          = '0;
            state_d      = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_dev = 1'b1;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_cov = 1'b1;
        if (!j_eq_i) begin
          j_d     = j_q + 2'd1;
          state_d = ST_MUL;
        end else begin
          j_d = '0;
          if (!i_last) begin
            i_d     = i_q + 2'd1;
            state_d = ST_IDLE;
          end else begin
            i_d = '0;
            if (({1'b0, si_q} + 17'd1) < ({1'b0, m1} + 17'd1)) begin
              si_d    = si_q + 16'd1;
              state_d = ST_IDLE;
            end else begin
              si_d    = '0;
              phase_d = PH_IDLE;
              state_d = ST_PDIV;
            end
          end
        end
      end
      ST_PDIV: begin
        if (m1 == '0) begin
          cmd_o.p_wr = 1'b1;
          i_d        = pair_done ? '0 : adv_i;
          j_d        = pair_done ? '0 : adv_j;
          if (pair_done) begin
            retry_d = 1'b0;
            state_d = ST_SLOAD;
          end
        end else begin
          cmd_o.pdiv_start = 1'b1;
          state_d          = ST_PWAIT;
        end
      end
      ST_PWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.p_wr = 1'b1;
          i_d        = pair_done ? '0 : adv_i;
          j_d        = pair_done ? '0 : adv_j;
          retry_d    = 1'b0;
          state_d    = pair_done ? ST_SLOAD : ST_PDIV;
        end
      end
      ST_SLOAD: begin
        cmd_o.s_load = 1'b1;
        r_d          = '0;
        state_d      = (j_q == '0) ? ST_CLAMP : ST_RDA;
      end
      ST_RDA: begin
        cmd_o.la_rd = 1'b1;
        state_d     = ST_RDB;
      end
      ST_RDB: begin
        cmd_o.lb_mul = 1'b1;
        state_d      = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.s_sub = 1'b1;
        if ((r_q + 2'd1) == j_q) begin
          r_d     = '0;
          state_d = ST_CLAMP;
        end else begin
          r_d     = r_q + 2'd1;
          state_d = ST_RDA;
        end
      end
      ST_CLAMP: begin
        cmd_o.s_clamp = 1'b1;
        state_d       = ST_CHECK;
      end
      ST_CHECK: begin
        if (j_eq_i) begin
          if (stat_i.s_le0) begin
            i_d = '0;
            j_d = '0;
            if (!retry_q) begin
              retry_d = 1'b1;
              state_d = ST_SLOAD;
            end else begin
              state_d = ST_FAIL;
            end
          end else begin
            cmd_o.sqrt_start = 1'b1;
            state_d          = ST_SQWAIT;
          end
        end else begin
          cmd_o.ldiv_start = 1'b1;
          state_d          = ST_LDWAIT;
        end
      end
      ST_SQWAIT: begin
        if (stat_i.sqrt_done) begin
          cmd_o.l_wr_sqrt = 1'b1;
          i_d             = pair_done ? '0 : adv_i;
          j_d             = pair_done ? '0 : adv_j;
          pt_d            = '0;
          el_d            = '0;
          state_d         = pair_done ? ST_EMIT : ST_SLOAD;
        end
      end
      ST_LDWAIT: begin
        if (stat_i.div_done) begin
          cmd_o.l_wr_div = 1'b1;
          i_d            = pair_done ? '0 : adv_i;
          j_d            = pair_done ? '0 : adv_j;
          pt_d           = '0;
          el_d           = '0;
          state_d        = pair_done ? ST_EMIT : ST_SLOAD;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.r    = col_full[IDX_W-1:0];
        cmd_o.last = pt_final && el_last;
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          if (el_last) begin
            el_d = '0;
            if (pt_final) begin
              pt_d    = '0;
              state_d = ST_IDLE;
            end else begin
              pt_d = pt_q + 4'd1;
            end
          end else begin
            el_d = el_q + 2'd1;
          end
        end
      end
      ST_FAIL: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_fail = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a write to dims or sample_count drops any step in progress
    if (cfg_we_i && (cfg_idx_i == REG_DIMS || cfg_idx_i == REG_SAMPLES)) begin
      if (cfg_idx_i == REG_DIMS) begin
        dims_d = cfg_wdata_i[2:0];
      end else begin
        samples_d = cfg_wdata_i;
      end
      phase_d = PH_IDLE;
      state_d = ST_IDLE;
      i_d     = '0;
      j_d     = '0;
      r_d     = '0;
      si_d    = '0;
    end
  end

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      dims_q      <= 3'd4;
      samples_q   <= 16'd2;
      i_q         <= '0;
      j_q         <= '0;
      r_q         <= '0;
      si_q        <= '0;
      pt_q        <= '0;
      el_q        <= '0;
      retry_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      dims_q      <= dims_d;
      samples_q   <= samples_d;
      i_q         <= i_d;
      j_q         <= j_d;
      r_q         <= r_d;
      si_q        <= si_d;
      pt_q        <= pt_d;
      el_q        <= el_d;
      retry_q     <= retry_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken one");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, i_q} < k))
    else $error("row index beyond dimension");

  a_lower_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (j_q <= i_q))
    else $error("column index above row");

  a_inner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDA || state_q == ST_RDB || state_q == ST_SUB) |-> (r_q < j_q))
    else $error("inner index out of range");

endmodule

// ===== rtl/ut_sigma_point_generator_unit.sv =====
// Sigma point generator, Cholesky form, one time step per run.
// Input channel (in_valid_i / in_ready_o): each item is an opcode and a Q8.24
// value. Send K mean elements (opcode 0), then M sample vectors of K elements
// each (opcode 1). Each sample item at position e runs one multiply and one
// accumulate in the shared multiply-accumulate per covariance entry of row e.
// After the last sample element the block goes busy: each of the K*(K+1)/2
// covariance entries is divided by M-1 in the divider (zero when M is 0 or 1),
// then each factor entry subtracts its inner product terms and takes a square
// root (diagonal) or a division (below it); a failed attempt is redone once.
// Output channel (out_valid_o / out_ready_i): 2K+1 sigma points, K elements
// each, one item per cycle while the receiver takes them, or one item with
// failed_o set. An output register holds each item; a stall simply holds the
// sequence. New input is taken only after the final item is loaded.
// Configuration: cfg_we_i writes dims (index 0) or sample_count (index 1);
// either write drops any step in progress. Reset sets K = 4, M = 2 and idles.
module ut_sigma_point_generator_unit import utsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_res_o,
  output logic [3:0]  point_index_o,
  output logic [1:0]  element_index_o,
  output logic        failed_o,
  output logic        last_o
);

  utsp_cmd_t  cmd;
  utsp_stat_t stat;

  // sequencing, counters and configuration
  utsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // stores, multiply-accumulate, divider, square root, output register
  utsp_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_value_i      (value_i),
    .stat_o          (stat),
    .value_res_o     (value_res_o),
    .point_index_o   (point_index_o),
    .element_index_o (element_index_o),
    .failed_o        (failed_o),
    .last_o          (last_o)
  );

endmodule
